FILE: rtl/stable_merge_sort_ids_unit_defines.svh
// Assertion macros shared by the checker files of the merge sort unit.
// Depends on nothing; every macro samples on the rising edge of clock.
`ifndef STABLE_MERGE_SORT_IDS_UNIT_DEFINES_SVH
`define STABLE_MERGE_SORT_IDS_UNIT_DEFINES_SVH

// Plain property, held off while reset is high
`define SMSI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Antecedent implies consequent on the next edge
`define SMSI_ASSERT_NEXT(label, ante, cons, msg) \
   `SMSI_ASSERT(label, (ante) |=> (cons), msg)

`endif

FILE: rtl/smsi_pkg.sv
// Shared sizes, payload structs and buffer port types of the merge sort unit.
// Depends on nothing; imported by the buffer, the top level and the checker.
`default_nettype none

package smsi_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int KEY_BITS  = 32;
   localparam int ID_BITS   = 16;

   // Count holds 0..MAX_ITEMS, address 0..MAX_ITEMS-1, pointer sums reach 3*MAX_ITEMS
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int ADDR_W = $clog2(MAX_ITEMS);
   localparam int PTR_W  = CNT_W + 2;

   // Register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DESCENDING     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_USE_POSITION   = CSR_IDX_W'(1);

   typedef struct packed {
      logic signed [KEY_BITS-1:0] sort_key;
      logic [ID_BITS-1:0]         item_id;
      logic                       last_item;
   } req_payload_type;

   typedef struct packed {
      logic [ID_BITS-1:0]         sorted_id;
      logic signed [KEY_BITS-1:0] sorted_key;
      logic                       last_out;
      logic                       overflow;
   } rsp_payload_type;

   // One stored item
   typedef struct packed {
      logic signed [KEY_BITS-1:0] key;
      logic [ID_BITS-1:0]         id;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         data;
   } buf_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr0;
      logic [ADDR_W-1:0] addr1;
   } buf_rd_type;

endpackage

`default_nettype wire

FILE: rtl/stable_merge_sort_ids_unit.sv
// Load: one request per cycle while req_ready is high, written straight to buffer A.
// Sort: per pass a setup state, then a GROUP state per run pair and a read and a write
// state per item through the single key comparator; ceil(log2(n)) passes for n loaded
// items, then a final setup state. Emit: read, then load each result; stalls hold it.
// Synchronous active-high reset clears the load count, overflow flag, registers, output.
`default_nettype none

module stable_merge_sort_ids_unit
   import smsi_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_payload_type       req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_payload_type            rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SETUP,
      ST_GROUP,
      ST_MREAD,
      ST_MWRITE,
      ST_EREAD,
      ST_ELOAD
   } state_type;

   state_type       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic            dropped_ff, dropped_in;
   logic            desc_ff, desc_in;
   logic            pos_id_ff, pos_id_in;
   logic [PTR_W-1:0] size_ff, size_in;
   logic [CNT_W-1:0] put_ff, put_in;
   logic [CNT_W-1:0] p0_ff, p0_in;
   logic [CNT_W-1:0] p1_ff, p1_in;
   logic [CNT_W-1:0] e0_ff, e0_in;
   logic [CNT_W-1:0] e1_ff, e1_in;
   logic            src_b_ff, src_b_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   buf_wr_type a_wr, b_wr;
   buf_rd_type rd_req;
   entry_type  a_rd0, a_rd1, b_rd0, b_rd1;
   entry_type  src0, src1, merge_entry, load_entry;
   logic       load_we, merge_we, take_second, key_gt, key_lt;
   logic [CNT_W-1:0] put_nxt;
   logic [PTR_W-1:0] n_ext, sum0, sum1;

   smsi_buffer u_buf_a (
      .clock    (clock),
      .wr       (a_wr),
      .rd       (rd_req),
      .rd_data0 (a_rd0),
      .rd_data1 (a_rd1)
   );

   smsi_buffer u_buf_b (
      .clock    (clock),
      .wr       (b_wr),
      .rd       (rd_req),
      .rd_data0 (b_rd0),
      .rd_data1 (b_rd1)
   );

   // Source side of the current pass
   assign src0 = src_b_ff ? b_rd0 : a_rd0;
   assign src1 = src_b_ff ? b_rd1 : a_rd1;

   // Shared key comparator; equal keys keep the first run's item
   assign key_gt      = $signed(src0.key) > $signed(src1.key);
   assign key_lt      = $signed(src0.key) < $signed(src1.key);
   assign take_second = (p0_ff >= e0_ff) ||
                        ((p1_ff < e1_ff) && (desc_ff ? key_lt : key_gt));
   assign merge_entry = take_second ? src1 : src0;

   assign put_nxt = put_ff + CNT_W'(1);
   assign n_ext   = PTR_W'(count_ff);
   assign sum0    = PTR_W'(put_ff) + size_ff;
   assign sum1    = sum0 + size_ff;

   // Request intake
   assign req_ready  = (state_ff == ST_LOAD);
   assign load_we    = req_valid && req_ready && (count_ff < CNT_W'(MAX_ITEMS));
   assign merge_we   = (state_ff == ST_MWRITE);
   assign load_entry = '{key: req_data.sort_key,
                         id:  pos_id_ff ? ID_BITS'(count_ff) : req_data.item_id};

   // Buffer ports: loads go to A, merges write the side opposite the source
   always_comb begin
      a_wr.en   = load_we || (merge_we && src_b_ff);
      a_wr.addr = load_we ? count_ff[ADDR_W-1:0] : put_ff[ADDR_W-1:0];
      a_wr.data = load_we ? load_entry : merge_entry;
      b_wr.en   = merge_we && !src_b_ff;
      b_wr.addr = put_ff[ADDR_W-1:0];
      b_wr.data = merge_entry;
      rd_req.en = (state_ff == ST_MREAD) || (state_ff == ST_EREAD);
      rd_req.addr0 = (state_ff == ST_EREAD) ? put_ff[ADDR_W-1:0] : p0_ff[ADDR_W-1:0];
      rd_req.addr1 = p1_ff[ADDR_W-1:0];
   end

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      desc_in      = desc_ff;
      pos_id_in    = pos_id_ff;
      size_in      = size_ff;
      put_in       = put_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      e0_in        = e0_ff;
      e1_in        = e1_ff;
      src_b_in     = src_b_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // Register writes are for the user to make only while idle; the block does not enforce it
      if (csr_we) begin
         case (csr_index)
            CSR_DESCENDING:   desc_in   = csr_wdata[0];
            CSR_USE_POSITION: pos_id_in = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (load_we) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_data.last_item) begin
                  size_in  = PTR_W'(1);
                  put_in   = '0;
                  src_b_in = 1'b0;
                  state_in = ST_SETUP;
               end
            end
         end
         // Start a pass, or emit once the run covers all items
         ST_SETUP: begin
            put_in   = '0;
            state_in = (size_ff < n_ext) ? ST_GROUP : ST_EREAD;
         end
         // Bounds of the next run pair
         ST_GROUP: begin
            e0_in    = (sum0 < n_ext) ? sum0[CNT_W-1:0] : count_ff;
            e1_in    = (sum1 < n_ext) ? sum1[CNT_W-1:0] : count_ff;
            p0_in    = put_ff;
            p1_in    = (sum0 < n_ext) ? sum0[CNT_W-1:0] : count_ff;
            state_in = ST_MREAD;
         end
         ST_MREAD: begin
            state_in = ST_MWRITE;
         end
         // Write the chosen head, advance its run
         ST_MWRITE: begin
            if (take_second) begin
               p1_in = p1_ff + CNT_W'(1);
            end else begin
               p0_in = p0_ff + CNT_W'(1);
            end
            put_in = put_nxt;
            if (put_nxt == e1_ff) begin
               if (e1_ff == count_ff) begin
                  src_b_in = !src_b_ff;
                  size_in  = size_ff << 1;
                  state_in = ST_SETUP;
               end else begin
                  state_in = ST_GROUP;
               end
            end else begin
               state_in = ST_MREAD;
            end
         end
         ST_EREAD: begin
            state_in = ST_ELOAD;
         end
         // Hand one result to the output register when it frees up
         ST_ELOAD: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{sorted_id:  src0.id,
                                sorted_key: src0.key,
                                last_out:   (put_nxt == count_ff),
                                overflow:   dropped_ff};
               put_in = put_nxt;
               if (put_nxt == count_ff) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end else begin
                  state_in = ST_EREAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         desc_ff      <= 1'b0;
         pos_id_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         desc_ff      <= desc_in;
         pos_id_ff    <= pos_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      size_ff     <= size_in;
      put_ff      <= put_in;
      p0_ff       <= p0_in;
      p1_ff       <= p1_in;
      e0_ff       <= e0_in;
      e1_ff       <= e1_in;
      src_b_ff    <= src_b_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/smsi_buffer.sv
// One ping-pong buffer: MAX_ITEMS entries, one write port, two registered reads.
// Depends on smsi_pkg for entry and port types.
`default_nettype none

module smsi_buffer
   import smsi_pkg::*;
(
   input  wire logic       clock,
   input  wire buf_wr_type wr,
   input  wire buf_rd_type rd,
   output entry_type       rd_data0,
   output entry_type       rd_data1
);

   entry_type mem [MAX_ITEMS];
   entry_type rd_data0_ff;
   entry_type rd_data1_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read two entries, hold the data until the next read
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data0_ff <= mem[rd.addr0];
         rd_data1_ff <= mem[rd.addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

`default_nettype wire

FILE: rtl/smsi_checker.sv
// Port-level checks for the merge sort unit, attached by bind to the top level.
// Depends on smsi_pkg and the assertion macros in the defines header.
`default_nettype none
`include "stable_merge_sort_ids_unit_defines.svh"

module smsi_checker
   import smsi_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_ready,
   input wire req_payload_type req_data,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire rsp_payload_type rsp_data
);

   // Stalled result stays put
   `SMSI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_data), "result changed while stalled")

   // Final request of a set closes the input while sorting
   `SMSI_ASSERT_NEXT(a_last_req_blocks, req_valid && req_ready && req_data.last_item,
                     !req_ready, "input open after final request")

   // Input stays closed while a result other than the final one waits
   `SMSI_ASSERT(a_mid_rsp_blocks, (rsp_valid && !rsp_data.last_out) |-> !req_ready,
                "input open mid-set")

endmodule

bind stable_merge_sort_ids_unit smsi_checker u_smsi_checker (.*);

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for stable_merge_sort_ids_unit: loads key/id sets, predicts the
// stable sorted order and compares every emitted result. Depends on smsi_pkg and the DUT.
`timescale 1ns / 1ps

module tb_top;
   import smsi_pkg::*;

   localparam logic signed [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};
   localparam logic signed [KEY_BITS-1:0] KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};
   localparam int SETTLE_CYCLES   = 24;
   localparam int ITEMS_PER_PHASE = 7;

   // Predicts the sorted order of each set and checks results against it
   class sorted_order_tracker;
      logic signed [KEY_BITS-1:0] key_store [MAX_ITEMS];
      logic [ID_BITS-1:0]         id_store [MAX_ITEMS];
      int unsigned                loaded_count;
      bit                         dropped;
      bit                         descending;
      bit                         position_as_id;
      rsp_payload_type            expected_sorted [$];
      int unsigned                mismatches;
      int unsigned                results_seen;
      int unsigned                sets_sorted;
      int unsigned                overflow_sets;

      function void set_register(logic [CSR_IDX_W-1:0] index, bit value);
         if (index == CSR_DESCENDING) descending = value;
         else if (index == CSR_USE_POSITION) position_as_id = value;
      endfunction

      function int pending();
         return expected_sorted.size();
      endfunction

      function void note_request(req_payload_type item);
         logic signed [KEY_BITS-1:0] keys [MAX_ITEMS];
         logic [ID_BITS-1:0]         ids [MAX_ITEMS];
         logic signed [KEY_BITS-1:0] hold_key;
         logic [ID_BITS-1:0]         hold_id;
         rsp_payload_type            result;
         int                         j;
         // store the request, or drop it once the store is full
         if (loaded_count < MAX_ITEMS) begin
            key_store[loaded_count] = item.sort_key;
            id_store[loaded_count]  = position_as_id ? ID_BITS'(loaded_count) : item.item_id;
            loaded_count++;
         end else begin
            dropped = 1'b1;
         end
         if (!item.last_item) return;
         for (int i = 0; i < loaded_count; i++) begin
            keys[i] = key_store[i];
            ids[i]  = id_store[i];
         end
         // stable insertion sort: move an entry only past strictly out-of-order keys
         for (int i = 1; i < loaded_count; i++) begin
            j = i;
            while (j > 0 && (descending ? (keys[j-1] < keys[j]) : (keys[j-1] > keys[j]))) begin
               hold_key  = keys[j-1];
               hold_id   = ids[j-1];
               keys[j-1] = keys[j];
               ids[j-1]  = ids[j];
               keys[j]   = hold_key;
               ids[j]    = hold_id;
               j--;
            end
         end
         for (int k = 0; k < loaded_count; k++) begin
            result.sorted_id  = ids[k];
            result.sorted_key = keys[k];
            result.last_out   = (k == loaded_count - 1);
            result.overflow   = dropped;
            expected_sorted.push_back(result);
         end
         sets_sorted++;
         if (dropped) overflow_sets++;
         loaded_count = 0;
         dropped      = 1'b0;
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         results_seen++;
         // flag a result that arrives with nothing waiting
         if (expected_sorted.size() == 0) begin
            if (mismatches < 10)
               $display("ERROR: unexpected result id=%h key=%0d last=%b overflow=%b",
                        got.sorted_id, got.sorted_key, got.last_out, got.overflow);
            mismatches++;
            return;
         end
         want = expected_sorted.pop_front();
         if (got.sorted_id !== want.sorted_id || got.sorted_key !== want.sorted_key ||
             got.last_out !== want.last_out || got.overflow !== want.overflow) begin
            if (mismatches < 10) begin
               $display("ERROR: result %0d expected id=%h key=%0d last=%b overflow=%b",
                        results_seen, want.sorted_id, want.sorted_key, want.last_out,
                        want.overflow);
               $display("       got id=%h key=%0d last=%b overflow=%b",
                        got.sorted_id, got.sorted_key, got.last_out, got.overflow);
            end
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_payload_type       req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_payload_type       rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   sorted_order_tracker tracker = new();
   int unsigned         send_idle_pct;
   int unsigned         rsp_stall_pct;
   int unsigned         requests_sent;

   stable_merge_sort_ids_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Stall the result channel at random, changing only on the falling edge
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = !reset && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_result(rsp_data);
   end

   // Give up on a hung run
   initial begin
      #(4_000_000);
      $display("stable_merge_sort_ids_unit test failed");
      $finish;
   end

   task automatic write_register(input logic [CSR_IDX_W-1:0] index, input bit value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_we    = 1'b0;
      tracker.set_register(index, value);
   endtask

   task automatic send_request(input logic signed [KEY_BITS-1:0] key,
                               input logic [ID_BITS-1:0] id, input bit last);
      @(negedge clock);
      // idle the request channel for a random stretch
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data.sort_key  = key;
      req_data.item_id   = id;
      req_data.last_item = last;
      req_valid          = 1'b1;
      // hold the request until it is taken
      do @(posedge clock); while (!req_ready);
      tracker.note_request(req_data);
      requests_sent++;
   endtask

   // Drop valid, wait for all outstanding results, then let the block settle
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [KEY_BITS-1:0] random_key();
      case ($urandom_range(3))
         0: return KEY_BITS'(int'($urandom_range(8)) - 4);
         1: begin
            case ($urandom_range(3))
               0: return KEY_MIN;
               1: return KEY_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return KEY_BITS'($urandom);
      endcase
   endfunction

   task automatic send_random_set(input int count);
      for (int i = 0; i < count; i++)
         send_request(random_key(), ID_BITS'($urandom_range(0, 65535)), i == count - 1);
   endtask

   initial begin
      logic signed [KEY_BITS-1:0] extreme_keys [8];
      logic [ID_BITS-1:0]         extreme_ids [8];
      int                         phase_items;
      int                         set_size;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      requests_sent = 0;
      extreme_keys = '{KEY_MIN, KEY_MAX, 0, -1, 5, -1, 5, KEY_MIN};
      extreme_ids  = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0002,
                       16'h0003, 16'h0004, 16'h0005, 16'h0006};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: single item, extreme and repeated keys, equal-key pair
      write_register(CSR_DESCENDING, 1'b0);
      write_register(CSR_USE_POSITION, 1'b0);
      send_request(KEY_MAX, 16'hFFFF, 1'b1);
      for (int i = 0; i < 8; i++) send_request(extreme_keys[i], extreme_ids[i], i == 7);
      send_request('0, 16'hAAAA, 1'b0);
      send_request('0, 16'h5555, 1'b1);
      wait_for_drain();
      write_register(CSR_DESCENDING, 1'b1);
      for (int i = 0; i < 8; i++) send_request(extreme_keys[i], extreme_ids[i], i == 7);

      // Random phases across both registers and all idle patterns
      for (int phase = 0; phase < 8; phase++) begin
         wait_for_drain();
         write_register(CSR_DESCENDING, phase[0]);
         write_register(CSR_USE_POSITION, phase[1]);
         case (phase / 2)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 68; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 68; end
            default: begin send_idle_pct = 32; rsp_stall_pct = 32; end
         endcase
         // overfill the store in one phase
         if (phase == 6) send_random_set(MAX_ITEMS + $urandom_range(1, 6));
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) begin
            set_size = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
            send_random_set(set_size);
            phase_items += set_size;
         end
      end

      wait_for_drain();
      $display("Sent %0d requests in %0d sets (%0d with drops), checked %0d results",
               requests_sent, tracker.sets_sorted, tracker.overflow_sets,
               tracker.results_seen);
      $display("Covered both orders, input ids and load positions, %0d mismatches",
               tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("stable_merge_sort_ids_unit test passed");
      end else begin
         $display("stable_merge_sort_ids_unit test failed");
      end
      $finish;
   end

endmodule
